/* rtl/rvb_pkg.sv */
package rvb_pkg;

  localparam int ENTRIES_DEF  = 64;
  localparam int DIM_DEF      = 16;
  localparam int REF_BITS_DEF = 16;

  localparam int KEY_W     = 40;
  localparam int IDX_MAX_W = 12;

  localparam logic [2:0] FN_FIND    = 3'd0;
  localparam logic [2:0] FN_INSERT  = 3'd1;
  localparam logic [2:0] FN_RESPOND = 3'd2;
  localparam logic [2:0] FN_UPDATE  = 3'd3;
  localparam logic [2:0] FN_BATCH   = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_ADDREF = 2'd0,
    OP_CREATE = 2'd1,
    OP_DROP   = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic                 active;
    logic                 hit;
    logic                 hit_gt1;
    logic [IDX_MAX_W-1:0] hit_idx;
    logic                 free;
    logic [IDX_MAX_W-1:0] free_idx;
  } token_t;

  typedef struct packed {
    logic                 en;
    op_kind_t             kind;
    logic [IDX_MAX_W-1:0] slot;
  } cell_op_t;

endpackage

/* rtl/rvb_cell.sv */
module rvb_cell #(
  parameter int INDEX    = 0,
  parameter int REF_BITS = rvb_pkg::REF_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [rvb_pkg::KEY_W-1:0] key_i,
  input  rvb_pkg::token_t          tok_i,
  output rvb_pkg::token_t          tok_o,
  input  rvb_pkg::cell_op_t        op_i
);

  logic                      valid_r;
  logic [rvb_pkg::KEY_W-1:0] key_r;
  logic [REF_BITS-1:0]       refs_r;
  rvb_pkg::token_t           tok_r;
  rvb_pkg::token_t           tok_nxt;
  logic                      sel;

  localparam logic [rvb_pkg::IDX_MAX_W-1:0] MY_IDX = rvb_pkg::IDX_MAX_W'(INDEX);

  assign sel   = op_i.en && (op_i.slot == MY_IDX);
  assign tok_o = tok_r;

  always_comb begin
    tok_nxt = tok_i;
    if (!tok_i.hit && valid_r && (key_r == key_i)) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_idx = MY_IDX;
      tok_nxt.hit_gt1 = (refs_r > REF_BITS'(1));
    end
    if (!tok_i.free && !valid_r) begin
      tok_nxt.free     = 1'b1;
      tok_nxt.free_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (sel) begin
        case (op_i.kind)
          rvb_pkg::OP_CREATE: begin
            valid_r <= 1'b1;
            key_r   <= key_i;
            refs_r  <= REF_BITS'(1);
          end
          rvb_pkg::OP_ADDREF: begin
            if (refs_r != '1) begin
              refs_r <= refs_r + REF_BITS'(1);
            end
          end
          rvb_pkg::OP_DROP: begin
            if (refs_r > REF_BITS'(1)) begin
              refs_r <= refs_r - REF_BITS'(1);
            end else begin
              valid_r <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* rtl/refcounted_vector_buffer_core.sv */
// Channel   Handshake                Payload
// in        start && !busy           in_func .. in_batch_delta
// out       out_strobe (one cycle)   out_status .. out_entry_count
//
// Add batch and unknown functions report in the cycle after the transfer and stay idle.
// A keyed operation sends a token down the row of ENTRIES cells in the cycle after the
// transfer; its result is registered once the token leaves the last cell.
// A create then clears the vector, with the element value in element 0, and a respond
// that hits streams DIM elements from the vector memory, one per cycle, then drains.
// Reset is synchronous; the vector memory is not cleared, since new entries are
// cleared on creation. The receiver takes every transfer and cannot stall.
module refcounted_vector_buffer_core #(
  parameter int ENTRIES  = rvb_pkg::ENTRIES_DEF,
  parameter int DIM      = rvb_pkg::DIM_DEF,
  parameter int REF_BITS = rvb_pkg::REF_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_table_index,
  input  logic signed [31:0] in_feature_id,
  input  logic [3:0]  in_elem_index,
  input  logic [31:0] in_elem_value,
  input  logic        in_batch_end,
  input  logic signed [31:0] in_batch_delta,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [3:0]  out_out_index,
  output logic [31:0] out_out_value,
  output logic        out_last,
  output logic signed [31:0] out_batch_count,
  output logic [6:0]  out_entry_count
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int AW    = $clog2(ENTRIES * DIM);
  localparam int EW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int DEPTH = ENTRIES * DIM;
  localparam logic [EW-1:0] K_LAST = EW'(DIM - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_CLEAR  = 5'b00100,
    S_STREAM = 5'b01000,
    S_DRAIN  = 5'b10000
  } state_t;

  state_t                    state_r;
  logic [2:0]                func_r;
  logic [rvb_pkg::KEY_W-1:0] key_r;
  logic [3:0]                ei_r;
  logic [31:0]               ev_r;
  logic [31:0]               batch_r;
  logic [CW-1:0]             live_r;
  logic [IW-1:0]             fresh_r;
  logic                      fresh_ok_r;
  logic [AW-1:0]             base_r;
  logic [EW-1:0]             k_r;
  logic                      launch_r;

  logic        strobe_r;
  logic [1:0]  status_r;
  logic        found_r;
  logic [3:0]  index_r;
  logic        last_r;
  logic        from_mem_r;
  logic [31:0] mem_q_r;

  logic [31:0] mem [DEPTH];

  rvb_pkg::token_t   tok [ENTRIES+1];
  rvb_pkg::cell_op_t op;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [31:0]       mem_wd;
  logic              scan_done;
  logic [IW-1:0]     sidx;
  logic [IW-1:0]     fidx;
  logic              ei_ok;
  logic              keyed;
  logic              accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign keyed  = (in_func == rvb_pkg::FN_FIND) || (in_func == rvb_pkg::FN_INSERT) ||
                  (in_func == rvb_pkg::FN_RESPOND) || (in_func == rvb_pkg::FN_UPDATE);

  assign tok[0] = '{active: launch_r, default: '0};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    rvb_cell #(
      .INDEX    (i),
      .REF_BITS (REF_BITS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .key_i (key_r),
      .tok_i (tok[i]),
      .tok_o (tok[i+1]),
      .op_i  (op)
    );
  end

  assign scan_done = (state_r == S_SCAN) && tok[ENTRIES].active;
  assign sidx      = IW'(tok[ENTRIES].hit_idx);
  assign fidx      = IW'(tok[ENTRIES].free_idx);
  assign ei_ok     = (32'(ei_r) < DIM);

  always_comb begin
    op      = '0;
    op.kind = rvb_pkg::OP_ADDREF;
    op.slot = tok[ENTRIES].hit_idx;
    mem_we  = 1'b0;
    mem_wa  = AW'(sidx) * AW'(DIM) + AW'(ei_r);
    mem_wd  = ev_r;
    if (scan_done) begin
      case (func_r)
        rvb_pkg::FN_FIND: begin
          op.en = tok[ENTRIES].hit;
        end
        rvb_pkg::FN_INSERT: begin
          if (ei_r == 4'd0) begin
            if (tok[ENTRIES].hit) begin
              op.en = 1'b1;
            end else if (tok[ENTRIES].free) begin
              op.en   = 1'b1;
              op.kind = rvb_pkg::OP_CREATE;
              op.slot = tok[ENTRIES].free_idx;
            end
          end else begin
            mem_we = tok[ENTRIES].hit && fresh_ok_r && (fresh_r == sidx) && ei_ok;
          end
        end
        rvb_pkg::FN_RESPOND: begin
          op.en   = tok[ENTRIES].hit;
          op.kind = rvb_pkg::OP_DROP;
        end
        rvb_pkg::FN_UPDATE: begin
          mem_we = tok[ENTRIES].hit && ei_ok;
        end
        default: begin
        end
      endcase
    end else if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = base_r + AW'(k_r);
      mem_wd = (k_r == '0) ? ev_r : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[base_r + AW'(k_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      batch_r    <= '0;
      live_r     <= '0;
      fresh_ok_r <= 1'b0;
      strobe_r   <= 1'b0;
      from_mem_r <= 1'b0;
      launch_r   <= 1'b0;
    end else begin
      strobe_r   <= 1'b0;
      from_mem_r <= 1'b0;
      launch_r   <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r <= in_func;
            key_r  <= {in_table_index, in_feature_id};
            ei_r   <= in_elem_index;
            ev_r   <= in_elem_value;
            if (keyed) begin
              state_r  <= S_SCAN;
              launch_r <= 1'b1;
              if ((in_func == rvb_pkg::FN_RESPOND) && in_batch_end) begin
                batch_r <= batch_r - 32'd1;
              end
            end else begin
              if (in_func == rvb_pkg::FN_BATCH) begin
                batch_r <= batch_r + in_batch_delta;
              end
              strobe_r <= 1'b1;
              status_r <= rvb_pkg::ST_OK;
              found_r  <= 1'b0;
              index_r  <= 4'd0;
              last_r   <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state_r  <= S_IDLE;
            strobe_r <= 1'b1;
            found_r  <= tok[ENTRIES].hit;
            status_r <= tok[ENTRIES].hit ? rvb_pkg::ST_OK : rvb_pkg::ST_MISS;
            index_r  <= 4'd0;
            last_r   <= 1'b1;
            k_r      <= '0;
            case (func_r)
              rvb_pkg::FN_INSERT: begin
                if (ei_r == 4'd0) begin
                  if (tok[ENTRIES].hit) begin
                    fresh_ok_r <= 1'b0;
                  end else if (!tok[ENTRIES].free) begin
                    fresh_ok_r <= 1'b0;
                    status_r   <= rvb_pkg::ST_FULL;
                  end else begin
                    live_r     <= live_r + CW'(1);
                    fresh_r    <= fidx;
                    fresh_ok_r <= 1'b1;
                    base_r     <= AW'(fidx) * AW'(DIM);
                    strobe_r   <= 1'b0;
                    state_r    <= S_CLEAR;
                  end
                end
              end
              rvb_pkg::FN_RESPOND: begin
                if (tok[ENTRIES].hit) begin
                  if (!tok[ENTRIES].hit_gt1) begin
                    live_r <= live_r - CW'(1);
                    if (fresh_ok_r && (fresh_r == sidx)) begin
                      fresh_ok_r <= 1'b0;
                    end
                  end
                  base_r   <= AW'(sidx) * AW'(DIM);
                  strobe_r <= 1'b0;
                  state_r  <= S_STREAM;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CLEAR: begin
          k_r <= k_r + EW'(1);
          if (k_r == K_LAST) begin
            k_r      <= '0;
            strobe_r <= 1'b1;
            status_r <= rvb_pkg::ST_OK;
            found_r  <= 1'b0;
            index_r  <= 4'd0;
            last_r   <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        S_STREAM: begin
          strobe_r   <= 1'b1;
          from_mem_r <= 1'b1;
          status_r   <= rvb_pkg::ST_OK;
          found_r    <= 1'b1;
          index_r    <= 4'(k_r);
          last_r     <= (k_r == K_LAST);
          k_r        <= k_r + EW'(1);
          if (k_r == K_LAST) begin
            k_r     <= '0;
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_found       = found_r;
  assign out_out_index   = index_r;
  assign out_out_value   = from_mem_r ? mem_q_r : 32'd0;
  assign out_last        = last_r;
  assign out_batch_count = batch_r;
  assign out_entry_count = 7'(live_r);

endmodule
